>>> sv/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CMD_W      = 2;
    localparam int CODE_W     = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 8;
    localparam int CUR_COL_W  = 8;
    localparam int COLOUR_W   = 4;
    localparam int CELL_W     = CODE_W + 2 * COLOUR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLOUR_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_SETCUR = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } t_cfg_idx;

    localparam logic [CODE_W-1:0]   CODE_NULL  = 8'd0;
    localparam logic [CODE_W-1:0]   CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0]   CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0]   CODE_BLANK = 8'd32;
    localparam logic [COLOUR_W-1:0] RST_FG     = 4'd5;
    localparam logic [COLOUR_W-1:0] RST_BG     = 4'd0;
    localparam logic [ROW_W-1:0]    HOME_ROW   = 8'd1;
    localparam logic [ROW_W-1:0]    ROW_MAX    = 8'd255;

    typedef struct packed {
        logic load;
        logic decode;
        logic copy;
        logic drain;
        logic fill;
        logic fill_rst;
        logic write_char;
        logic read;
        logic capture;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic no_write;
        logic need_scroll;
        logic in_range;
        logic ptr_last;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

>>> sv/tcw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_in_if
// Command channel: one item per console command.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::CMD_W-1:0]      cmd;
    logic [tcw_pkg::CODE_W-1:0]     char_code;
    logic [tcw_pkg::COL_W-1:0]      col;
    logic [tcw_pkg::ROW_W-1:0]      row;

    modport source (output valid, cmd, char_code, col, row, input ready);
    modport sink   (input valid, cmd, char_code, col, row, output ready);
endinterface
`default_nettype wire

>>> sv/tcw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_out_if
// Result channel: cell read back and cursor after each item.
// ----------------------------------------------------------------------------
interface tcw_out_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::CODE_W-1:0]     cell_char;
    logic [tcw_pkg::COLOUR_W-1:0]   cell_fg;
    logic [tcw_pkg::COLOUR_W-1:0]   cell_bg;
    logic [tcw_pkg::COL_W-1:0]      cursor_col;
    logic [tcw_pkg::ROW_W-1:0]      cursor_row;

    modport source (output valid, cell_char, cell_fg, cell_bg, cursor_col, cursor_row,
                    input ready);
    modport sink   (input valid, cell_char, cell_fg, cell_bg, cursor_col, cursor_row,
                    output ready);
endinterface
`default_nettype wire

>>> sv/tcw_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::CFG_IDX_W-1:0]    index;
    logic [tcw_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> sv/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: decodes each item and steps the screen sweeps and accesses.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_ctrl_cmd       o_cmd,
    output logic                     o_in_ready
);

    typedef enum logic [9:0] {
        S_INIT    = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_DECODE  = 10'b00_0000_0100,
        S_COPY    = 10'b00_0000_1000,
        S_DRAIN   = 10'b00_0001_0000,
        S_FILL    = 10'b00_0010_0000,
        S_WRITE   = 10'b00_0100_0000,
        S_READ    = 10'b00_1000_0000,
        S_CAPTURE = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.fill     = 1'b1;
                o_cmd.fill_rst = 1'b1;
                if (i_status.ptr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_status.cmd)
                    tcw_pkg::CMD_PUT: begin
                        if (i_status.no_write) begin
                            n_state = S_DONE;
                        end else if (i_status.need_scroll) begin
                            n_state = S_COPY;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end
                    tcw_pkg::CMD_READ: begin
                        n_state = i_status.in_range ? S_READ : S_DONE;
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        n_state = S_FILL;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_status.ptr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.ptr_last) begin
                    n_state = (i_status.cmd == tcw_pkg::CMD_CLEAR) ? S_DONE : S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_char = 1'b1;
                n_state          = S_DONE;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CAPTURE;
            end
            S_CAPTURE: begin
                o_cmd.capture = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

>>> sv/tcw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cursor, colours, screen memory, sweep pointer and result register.
// ----------------------------------------------------------------------------
module tcw_dp #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tcw_pkg::t_ctrl_cmd                i_cmd,
    output tcw_pkg::t_dp_status                    o_status,
    input  wire logic [tcw_pkg::CMD_W-1:0]         i_in_cmd,
    input  wire logic [tcw_pkg::CODE_W-1:0]        i_in_code,
    input  wire logic [tcw_pkg::COL_W-1:0]         i_in_col,
    input  wire logic [tcw_pkg::ROW_W-1:0]         i_in_row,
    input  wire logic                              i_cfg_valid,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic      [tcw_pkg::CELL_W-1:0]        o_out_cell,
    output logic      [tcw_pkg::COL_W-1:0]         o_out_col,
    output logic      [tcw_pkg::ROW_W-1:0]         o_out_row
);

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CCW   = tcw_pkg::CUR_COL_W;
    localparam int ROWW  = tcw_pkg::ROW_W;

    localparam logic [AW-1:0]   A_COLS   = AW'(SCREEN_COLS);
    localparam logic [AW-1:0]   A_KEEP   = AW'((SCREEN_ROWS - 1) * SCREEN_COLS);
    localparam logic [AW-1:0]   A_LAST   = AW'(CELLS - 1);
    localparam logic [CCW-1:0]  COLS_V   = CCW'(SCREEN_COLS);
    localparam logic [ROWW-1:0] ROWS_V   = ROWW'(SCREEN_ROWS);
    localparam logic [ROWW-1:0] LAST_ROW = ROWW'(SCREEN_ROWS - 1);

    logic [tcw_pkg::COLOUR_W-1:0] r_fg, n_fg, r_bg, n_bg;
    tcw_pkg::t_cmd                r_in_cmd, n_in_cmd;
    logic [tcw_pkg::CODE_W-1:0]   r_in_code, n_in_code;
    logic [tcw_pkg::COL_W-1:0]    r_in_col, n_in_col;
    logic [ROWW-1:0]              r_in_row, n_in_row;
    logic [CCW-1:0]               r_cur_col, n_cur_col;
    logic [ROWW-1:0]              r_cur_row, n_cur_row;
    logic [AW-1:0]                r_addr, n_addr;
    logic [AW-1:0]                r_ptr, n_ptr;
    logic                         r_wvalid, n_wvalid;
    logic [AW-1:0]                r_waddr, n_waddr;
    logic [tcw_pkg::CELL_W-1:0]   r_cell, n_cell;
    logic                         r_out_valid, n_out_valid;
    logic [tcw_pkg::CELL_W-1:0]   r_out_cell, n_out_cell;
    logic [tcw_pkg::COL_W-1:0]    r_out_col, n_out_col;
    logic [ROWW-1:0]              r_out_row, n_out_row;

    logic                         wrap;
    logic [ROWW-1:0]              row_inc;
    logic [CCW-1:0]               eff_col;
    logic [ROWW-1:0]              eff_row;
    logic                         scroll;
    logic [AW-1:0]                put_addr;
    logic [AW-1:0]                item_addr;
    logic                         is_brk;
    logic                         is_null;
    logic                         in_range;
    logic                         out_free;
    logic [tcw_pkg::CELL_W-1:0]   blank;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [tcw_pkg::CELL_W-1:0]   wr_data;
    logic [AW-1:0]                rd_addr;
    logic [tcw_pkg::CELL_W-1:0]   rd_data;

    assign wrap      = (r_cur_col >= COLS_V);
    assign row_inc   = (r_cur_row == tcw_pkg::ROW_MAX) ? r_cur_row : r_cur_row + 8'd1;
    assign eff_col   = wrap ? '0 : r_cur_col;
    assign eff_row   = wrap ? row_inc : r_cur_row;
    assign scroll    = (eff_row >= ROWS_V);
    assign put_addr  = scroll ? A_KEEP + AW'(eff_col)
                              : AW'(AW'(eff_row[RW-1:0]) * A_COLS) + AW'(eff_col);
    assign item_addr = AW'(AW'(r_in_row[RW-1:0]) * A_COLS) + AW'(r_in_col);
    assign is_brk    = (r_in_code == tcw_pkg::CODE_LF) || (r_in_code == tcw_pkg::CODE_CR);
    assign is_null   = (r_in_code == tcw_pkg::CODE_NULL);
    assign in_range  = ({1'b0, r_in_col} < COLS_V) && (r_in_row < ROWS_V);
    assign out_free  = !r_out_valid || i_out_ready;
    assign blank     = i_cmd.fill_rst ? {tcw_pkg::RST_BG, tcw_pkg::RST_FG, tcw_pkg::CODE_BLANK}
                                      : {r_bg, r_fg, tcw_pkg::CODE_BLANK};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = blank;
        if (r_wvalid) begin
            wr_en   = 1'b1;
            wr_addr = r_waddr;
            wr_data = rd_data;
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
        end else if (i_cmd.write_char) begin
            wr_en   = 1'b1;
            wr_addr = r_addr;
            wr_data = {r_bg, r_fg, r_in_code};
        end
    end

    assign rd_addr = i_cmd.copy ? r_ptr : r_addr;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_in_cmd    = r_in_cmd;
        n_in_code   = r_in_code;
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_addr      = r_addr;
        n_ptr       = r_ptr;
        n_wvalid    = 1'b0;
        n_waddr     = r_waddr;
        n_cell      = r_cell;
        n_out_valid = r_out_valid;
        n_out_cell  = r_out_cell;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;

        if (i_cfg_valid) begin
            case (tcw_pkg::t_cfg_idx'(i_cfg_index))
                tcw_pkg::CFG_FG: n_fg = i_cfg_data;
                tcw_pkg::CFG_BG: n_bg = i_cfg_data;
                default:         n_fg = r_fg;
            endcase
        end

        if (i_cmd.load) begin
            n_in_cmd  = tcw_pkg::t_cmd'(i_in_cmd);
            n_in_code = i_in_code;
            n_in_col  = i_in_col;
            n_in_row  = i_in_row;
        end

        if (i_cmd.decode) begin
            n_cell = '0;
            case (r_in_cmd)
                tcw_pkg::CMD_PUT: begin
                    if (is_brk) begin
                        n_cur_col = '0;
                        n_cur_row = row_inc;
                    end else if (!is_null) begin
                        n_cur_col = eff_col + 8'd1;
                        n_cur_row = scroll ? LAST_ROW : eff_row;
                        n_addr    = put_addr;
                        n_ptr     = A_COLS;
                    end
                end
                tcw_pkg::CMD_READ: begin
                    n_addr = item_addr;
                end
                tcw_pkg::CMD_CLEAR: begin
                    n_cur_col = '0;
                    n_cur_row = tcw_pkg::HOME_ROW;
                    n_ptr     = '0;
                end
                default: begin
                    n_cur_col = {1'b0, r_in_col};
                    n_cur_row = r_in_row;
                end
            endcase
        end

        if (i_cmd.copy) begin
            n_ptr    = r_ptr + 1'b1;
            n_wvalid = 1'b1;
            n_waddr  = r_ptr - A_COLS;
        end
        if (i_cmd.drain) begin
            n_ptr = A_KEEP;
        end
        if (i_cmd.fill) begin
            n_ptr = r_ptr + 1'b1;
        end
        if (i_cmd.capture) begin
            n_cell = rd_data;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            n_out_cell  = r_cell;
            n_out_col   = r_cur_col[tcw_pkg::COL_W-1:0];
            n_out_row   = r_cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg        <= tcw_pkg::RST_FG;
            r_bg        <= tcw_pkg::RST_BG;
            r_cur_col   <= '0;
            r_cur_row   <= tcw_pkg::HOME_ROW;
            r_ptr       <= '0;
            r_wvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_ptr       <= n_ptr;
            r_wvalid    <= n_wvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_cmd   <= n_in_cmd;
        r_in_code  <= n_in_code;
        r_in_col   <= n_in_col;
        r_in_row   <= n_in_row;
        r_addr     <= n_addr;
        r_waddr    <= n_waddr;
        r_cell     <= n_cell;
        r_out_cell <= n_out_cell;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
    end

    always_comb begin
        o_status             = '0;
        o_status.cmd         = r_in_cmd;
        o_status.no_write    = is_null || is_brk;
        o_status.need_scroll = scroll;
        o_status.in_range    = in_range;
        o_status.ptr_last    = (r_ptr == A_LAST);
        o_status.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_cell  = r_out_cell;
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;

endmodule
`default_nettype wire

>>> sv/text_console_writer.sv
`default_nettype none
// Each item taken is decoded; a set cursor, a null or line-break put and an off-screen
// read then load the result, a put first writes its cell and a read first reads and
// captures its cell. A new item can be taken in the cycle after the result loads. A put
// that scrolls copies rows up and blanks the bottom row, and a clear blanks every cell,
// all through the single write port. After reset all SCREEN_COLS*SCREEN_ROWS cells
// (2000 by default) are blanked, no item taken; register writes are taken throughout.
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen of character cells with cursor, line wrap and one-row scroll.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tcw_in_if.sink      i_item,
    tcw_out_if.source   o_result,
    tcw_cfg_if.sink     i_cfg
);

    tcw_pkg::t_ctrl_cmd          ctrl_cmd;
    tcw_pkg::t_dp_status         dp_status;
    logic                        in_ready;
    logic [tcw_pkg::CELL_W-1:0]  out_cell;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd),
        .o_in_ready (in_ready)
    );

    tcw_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_in_cmd    (i_item.cmd),
        .i_in_code   (i_item.char_code),
        .i_in_col    (i_item.col),
        .i_in_row    (i_item.row),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out_cell  (out_cell),
        .o_out_col   (o_result.cursor_col),
        .o_out_row   (o_result.cursor_row)
    );

    assign i_item.ready       = in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_result.cell_char = out_cell[tcw_pkg::CODE_W-1:0];
    assign o_result.cell_fg   = out_cell[tcw_pkg::CODE_W +: tcw_pkg::COLOUR_W];
    assign o_result.cell_bg   = out_cell[tcw_pkg::CODE_W + tcw_pkg::COLOUR_W +: tcw_pkg::COLOUR_W];

    a_fill_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.fill |-> !$past(ctrl_cmd.copy))
        else $error("fill overlaps the pending scroll copy write");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item taken while the previous one is in work");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(ctrl_cmd.finish))
        else $error("result shown without a finished item");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer: a directed opening, then
// random console traffic across several colour settings, with random idles
// on the command side and random stalls on the result side. A screen and
// cursor predictor in the bench checks every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int     COLS          = 80;
    localparam int     ROWS          = 25;
    localparam int     CELLS         = COLS * ROWS;
    localparam int     CLK_PERIOD    = 12;
    localparam int     RANDOM_ITEMS  = 1400;
    localparam int     PHASES        = 7;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     COL_TOP       = 2**COL_W - 1;
    localparam int     ROW_TOP       = 2**ROW_W - 1;
    localparam longint CYCLE_LIMIT   = 64'd1600 * (CELLS + 300) * 4;

    typedef struct {
        t_cmd               cmd;
        logic [CODE_W-1:0]  code;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } console_cmd_t;

    typedef struct {
        logic [CODE_W-1:0]   cell_char;
        logic [COLOUR_W-1:0] cell_fg;
        logic [COLOUR_W-1:0] cell_bg;
        logic [COL_W-1:0]    cursor_col;
        logic [ROW_W-1:0]    cursor_row;
    } cursor_report_t;

    logic i_clk;
    logic i_rst_n;

    tcw_in_if  u_item_if ();
    tcw_out_if u_result_if ();
    tcw_cfg_if u_cfg_if ();

    text_console_writer #(
        .SCREEN_COLS (COLS),
        .SCREEN_ROWS (ROWS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (u_item_if),
        .o_result (u_result_if),
        .i_cfg    (u_cfg_if)
    );

    // predicted console state
    logic [CELL_W-1:0]   screen [CELLS];
    int                  cur_col;
    int                  cur_row;
    logic [COLOUR_W-1:0] fg_now;
    logic [COLOUR_W-1:0] bg_now;

    console_cmd_t   cmd_backlog [$];
    cursor_report_t cursor_reports [$];

    int     n_items;
    int     n_results;
    int     n_mismatch;
    int     n_put;
    int     n_read;
    int     n_clear;
    int     n_setcur;
    int     n_scroll;
    int     n_cfg;
    int     in_hold;
    int     in_calm;
    int     out_stall;
    int     out_calm;
    longint cycles;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    always @(posedge i_clk) begin : cycle_guard
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d results seen",
                     cycles, n_results, n_items);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void blank_from(input int first);
        int i;
        for (i = first; i < CELLS; i++) begin
            screen[i] = {bg_now, fg_now, CODE_BLANK};
        end
    endfunction

    task automatic screen_step(input console_cmd_t c);
        cursor_report_t    r;
        logic [CELL_W-1:0] rd_cell;
        int                i;
        r = '{default: '0};
        case (c.cmd)
            CMD_PUT: begin
                n_put++;
                if (c.code == CODE_LF || c.code == CODE_CR) begin
                    cur_col = 0;
                    if (cur_row < ROW_MAX) cur_row++;
                end else if (c.code != CODE_NULL) begin
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        if (cur_row < ROW_MAX) cur_row++;
                    end
                    if (cur_row >= ROWS) begin
                        for (i = 0; i < (ROWS - 1) * COLS; i++) begin
                            screen[i] = screen[i + COLS];
                        end
                        blank_from((ROWS - 1) * COLS);
                        cur_row = ROWS - 1;
                        n_scroll++;
                    end
                    screen[cur_row * COLS + cur_col] = {bg_now, fg_now, c.code};
                    cur_col++;
                end
            end
            CMD_READ: begin
                n_read++;
                if (c.col < COLS && c.row < ROWS) begin
                    rd_cell = screen[c.row * COLS + c.col];
                    r.cell_char = rd_cell[CODE_W-1:0];
                    r.cell_fg   = rd_cell[CODE_W +: COLOUR_W];
                    r.cell_bg   = rd_cell[CODE_W + COLOUR_W +: COLOUR_W];
                end
            end
            CMD_CLEAR: begin
                n_clear++;
                blank_from(0);
                cur_col = 0;
                cur_row = HOME_ROW;
            end
            default: begin
                n_setcur++;
                cur_col = c.col;
                cur_row = c.row;
            end
        endcase
        r.cursor_col = cur_col[COL_W-1:0];
        r.cursor_row = cur_row[ROW_W-1:0];
        cursor_reports.push_back(r);
    endtask

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin : cmd_driver
        console_cmd_t took;
        console_cmd_t nxt;
        if (!i_rst_n) begin
            u_item_if.valid <= 1'b0;
            in_hold = 0;
            in_calm = 0;
        end else begin
            if (u_item_if.valid && u_item_if.ready) begin
                took.cmd  = t_cmd'(u_item_if.cmd);
                took.code = u_item_if.char_code;
                took.col  = u_item_if.col;
                took.row  = u_item_if.row;
                screen_step(took);
                if (in_calm > 0) begin
                    in_calm--;
                    in_hold = 0;
                end else if ($urandom_range(0, 99) < 2) begin
                    in_calm = $urandom_range(40, 120);
                    in_hold = 0;
                end else begin
                    in_hold = idle_len();
                end
            end
            if (!u_item_if.valid || u_item_if.ready) begin
                if (in_hold > 0 || cmd_backlog.size() == 0) begin
                    if (in_hold > 0) in_hold--;
                    u_item_if.valid <= 1'b0;
                end else begin
                    nxt = cmd_backlog.pop_front();
                    u_item_if.valid     <= 1'b1;
                    u_item_if.cmd       <= nxt.cmd;
                    u_item_if.char_code <= nxt.code;
                    u_item_if.col       <= nxt.col;
                    u_item_if.row       <= nxt.row;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_sink
        int p;
        if (!i_rst_n) begin
            u_result_if.ready <= 1'b0;
            out_stall = 0;
            out_calm  = 0;
        end else if (out_calm > 0) begin
            out_calm--;
            u_result_if.ready <= 1'b1;
        end else if (out_stall > 0) begin
            out_stall--;
            u_result_if.ready <= 1'b0;
        end else begin
            p = $urandom_range(0, 999);
            if (p < 5) begin
                out_calm = $urandom_range(50, 200);
                u_result_if.ready <= 1'b1;
            end else if (p < 250) begin
                out_stall = idle_len();
                u_result_if.ready <= 1'b0;
            end else begin
                u_result_if.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
                $display("[%0t] result %0d: %s expected %0d got %0d",
                         $realtime, n_results, name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        cursor_report_t want;
        if (i_rst_n && u_result_if.valid && u_result_if.ready) begin
            n_results++;
            if (cursor_reports.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("[%0t] result %0d arrived with nothing expected",
                             $realtime, n_results);
                end
            end else begin
                want = cursor_reports.pop_front();
                check_field("cell_char",  want.cell_char,  u_result_if.cell_char);
                check_field("cell_fg",    want.cell_fg,    u_result_if.cell_fg);
                check_field("cell_bg",    want.cell_bg,    u_result_if.cell_bg);
                check_field("cursor_col", want.cursor_col, u_result_if.cursor_col);
                check_field("cursor_row", want.cursor_row, u_result_if.cursor_row);
            end
        end
    end

    task automatic queue_cmd(input t_cmd cmd, input logic [CODE_W-1:0] code,
                             input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        console_cmd_t c;
        c.cmd  = cmd;
        c.code = code;
        c.col  = col;
        c.row  = row;
        cmd_backlog.push_back(c);
        n_items++;
    endtask

    function automatic logic [COL_W-1:0] aim_col();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return $urandom_range(0, COLS - 1);
        if (p < 70) return $urandom_range(COLS - 5, COLS);
        if (p < 85) return $urandom_range(COLS + 1, COL_TOP);
        return 0;
    endfunction

    function automatic logic [ROW_W-1:0] aim_row();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return $urandom_range(ROWS - 5, ROWS - 1);
        if (p < 70) return $urandom_range(0, ROWS - 1);
        if (p < 85) return $urandom_range(ROWS, ROW_TOP);
        return $urandom_range(ROW_TOP - 5, ROW_TOP);
    endfunction

    function automatic logic [CODE_W-1:0] glyph();
        logic [CODE_W-1:0] g;
        do begin
            g = $urandom_range(1, 255);
        end while (g == CODE_LF || g == CODE_CR);
        return g;
    endfunction

    function automatic logic [CODE_W-1:0] text_code();
        int p;
        p = $urandom_range(0, 99);
        if (p < 88) return glyph();
        if (p < 95) return $urandom_range(0, 1) ? CODE_LF : CODE_CR;
        return CODE_NULL;
    endfunction

    task automatic queue_read();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            queue_cmd(CMD_READ, $urandom, $urandom_range(0, COLS - 1),
                      $urandom_range(ROWS - 3, ROWS - 1));
        end else if (p < 85) begin
            queue_cmd(CMD_READ, $urandom, $urandom_range(0, COLS - 1),
                      $urandom_range(0, ROWS - 1));
        end else if (p < 93) begin
            queue_cmd(CMD_READ, $urandom, $urandom, $urandom_range(ROWS, ROW_TOP));
        end else begin
            queue_cmd(CMD_READ, $urandom, $urandom_range(COLS, COL_TOP), $urandom);
        end
    endtask

    task automatic queue_random(input int n);
        int goal;
        int kind;
        goal = n_items + n;
        while (n_items < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                if ($urandom_range(0, 1)) queue_cmd(CMD_SETCUR, $urandom, aim_col(), aim_row());
                repeat ($urandom_range(1, 30)) queue_cmd(CMD_PUT, text_code(), $urandom, $urandom);
                repeat ($urandom_range(0, 3)) queue_read();
            end else if (kind < 63) begin
                repeat ($urandom_range(1, 6)) queue_read();
            end else if (kind < 78) begin
                queue_cmd(CMD_SETCUR, $urandom, aim_col(), aim_row());
                repeat ($urandom_range(1, 3)) queue_cmd(CMD_PUT, glyph(), $urandom, $urandom);
                queue_read();
            end else if (kind < 88) begin
                if ($urandom_range(0, 1)) begin
                    queue_cmd(CMD_SETCUR, $urandom, aim_col(),
                              $urandom_range(ROW_TOP - 10, ROW_TOP));
                end
                repeat ($urandom_range(2, 10)) begin
                    if ($urandom_range(0, 1))
                        queue_cmd(CMD_PUT, $urandom_range(0, 1) ? CODE_LF : CODE_CR,
                                  $urandom, $urandom);
                    else
                        queue_cmd(CMD_PUT, glyph(), $urandom, $urandom);
                end
            end else if (kind < 93) begin
                queue_cmd(CMD_CLEAR, $urandom, $urandom, $urandom);
                repeat ($urandom_range(0, 5)) queue_cmd(CMD_PUT, text_code(), $urandom, $urandom);
                queue_read();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    queue_cmd(t_cmd'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                end
            end
        end
    endtask

    task automatic write_colour(input t_cfg_idx idx, input logic [COLOUR_W-1:0] val);
        @(posedge i_clk);
        u_cfg_if.valid <= 1'b1;
        u_cfg_if.index <= idx;
        u_cfg_if.data  <= val;
        do @(posedge i_clk); while (!u_cfg_if.ready);
        u_cfg_if.valid <= 1'b0;
        if (idx == CFG_FG) fg_now = val;
        else bg_now = val;
        n_cfg++;
    endtask

    task automatic wait_drained();
        while (n_results < n_items) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int ph;
        u_item_if.valid     = 1'b0;
        u_item_if.cmd       = CMD_PUT;
        u_item_if.char_code = '0;
        u_item_if.col       = '0;
        u_item_if.row       = '0;
        u_result_if.ready   = 1'b0;
        u_cfg_if.valid      = 1'b0;
        u_cfg_if.index      = CFG_FG;
        u_cfg_if.data       = '0;
        i_rst_n             = 1'b0;
        fg_now              = RST_FG;
        bg_now              = RST_BG;
        cur_col             = 0;
        cur_row             = HOME_ROW;
        blank_from(0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset screen, edge reads, null and line-break codes
        queue_cmd(CMD_READ,   8'd0,    7'd0,     8'd0);
        queue_cmd(CMD_READ,   8'd0,    COLS - 1, ROWS - 1);
        queue_cmd(CMD_READ,   8'd0,    COLS,     8'd0);
        queue_cmd(CMD_READ,   8'hFF,   COL_TOP,  ROW_TOP);
        queue_cmd(CMD_PUT,    CODE_NULL, 7'd0,   8'd0);
        queue_cmd(CMD_PUT,    8'd65,   7'd0,     8'd0);
        queue_cmd(CMD_PUT,    8'hFF,   7'd0,     8'd0);
        queue_cmd(CMD_READ,   8'd0,    7'd0,     HOME_ROW);
        queue_cmd(CMD_READ,   8'd0,    7'd1,     HOME_ROW);
        queue_cmd(CMD_PUT,    CODE_LF, 7'd0,     8'd0);
        queue_cmd(CMD_PUT,    CODE_CR, 7'd0,     8'd0);
        // right edge wrap into the bottom scroll
        queue_cmd(CMD_SETCUR, 8'd0,    COLS - 1, ROWS - 1);
        queue_cmd(CMD_PUT,    8'd120,  7'd0,     8'd0);
        queue_cmd(CMD_PUT,    8'd121,  7'd0,     8'd0);
        queue_cmd(CMD_READ,   8'd0,    COLS - 1, ROWS - 2);
        queue_cmd(CMD_READ,   8'd0,    7'd0,     ROWS - 1);
        queue_cmd(CMD_READ,   8'd0,    7'd1,     ROWS - 1);
        // cursor far off screen, row saturation
        queue_cmd(CMD_SETCUR, 8'd0,    COL_TOP,  ROW_TOP);
        queue_cmd(CMD_PUT,    CODE_LF, 7'd0,     8'd0);
        queue_cmd(CMD_PUT,    8'd122,  7'd0,     8'd0);
        queue_cmd(CMD_SETCUR, 8'd0,    COL_TOP,  ROW_TOP - 1);
        queue_cmd(CMD_PUT,    8'd200,  7'd0,     8'd0);
        queue_cmd(CMD_CLEAR,  8'd0,    7'd0,     8'd0);
        queue_cmd(CMD_READ,   8'd0,    COLS - 1, ROWS - 1);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_colour(CFG_FG, 4'hF);
                    write_colour(CFG_BG, 4'hF);
                end
                1: begin
                    write_colour(CFG_FG, 4'h0);
                    write_colour(CFG_BG, 4'h0);
                end
                2: begin
                    write_colour(CFG_BG, 4'hF);
                end
                3: begin
                    write_colour(CFG_FG, 4'hF);
                    write_colour(CFG_BG, 4'h0);
                end
                default: begin
                    write_colour(CFG_FG, $urandom);
                    if ($urandom_range(0, 1)) write_colour(CFG_BG, $urandom);
                end
            endcase
            queue_random(RANDOM_ITEMS / PHASES);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (cursor_reports.size() != 0) begin
            $display("%0d expected results never arrived", cursor_reports.size());
        end
        $display("Ran %0d commands: %0d put, %0d read, %0d clear, %0d set cursor",
                 n_items, n_put, n_read, n_clear, n_setcur);
        $display("%0d scrolls, %0d colour writes, %0d field mismatches",
                 n_scroll, n_cfg, n_mismatch);
        if (n_mismatch == 0 && cursor_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
